// File: sv/jlfqf_pkg.sv
// Shared constants, record types and field helpers for the J1939 frame queue and filter.
package jlfqf_pkg;

  // Ring sizes; each ring holds at most depth-1 frames.
  localparam int IN_DEPTH    = 16;
  localparam int OUT_DEPTH   = 16;
  localparam int IN_AW       = $clog2(IN_DEPTH);
  localparam int OUT_AW      = $clog2(OUT_DEPTH);
  localparam int MAX_BYTES   = 8;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // PDU format field values from this one upwards are PDU2 (broadcast).
  localparam logic [7:0] PDU2_PF_MIN = 8'd240;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_SEND    = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_TXREQ   = 2'd3;

  // Result kinds of an output beat.
  localparam logic [1:0] KIND_PDU   = 2'd0;
  localparam logic [1:0] KIND_SENT  = 2'd1;
  localparam logic [1:0] KIND_TX    = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  // Configuration register indexes.
  localparam int          REG_IDX_W  = 1;
  localparam logic [0:0]  REG_OWN    = 1'b0;
  localparam logic [0:0]  REG_GLOBAL = 1'b1;

  // One queued CAN frame as stored in a ring memory.
  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] id;
    logic [15:0] group;
    logic [7:0]  dest;
    logic [7:0]  source;
    logic [3:0]  len;
    logic [63:0] data;
    logic        primed;
    logic        last;
  } result_t;

  // Limits a byte count to the frame size.
  function automatic logic [3:0] clamp_len(input logic [3:0] len);
    return (len > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : len;
  endfunction

  // Clears payload bytes at or above the byte count.
  function automatic logic [63:0] keep_bytes(input logic [63:0] data, input logic [3:0] len);
    logic [63:0] mask;
    mask = '0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (4'(i) < len) begin
        mask[8*i +: 8] = 8'hFF;
      end
    end
    return data & mask;
  endfunction

  // Builds the 29-bit identifier of a message to send.
  function automatic logic [28:0] build_id(input logic [2:0] prio, input logic [17:0] pgn,
                                           input logic [7:0] dst, input logic [7:0] src);
    logic [17:0] grp;
    grp = pgn;
    // PDU1: the low byte of the PGN field carries the destination.
    if (pgn[15:8] < PDU2_PF_MIN) begin
      grp = {pgn[17:8], dst};
    end
    return {prio, grp, src};
  endfunction

endpackage

// File: sv/jlfqf_ram.sv
// Simple dual-port frame memory with one write port and a registered read port.
module jlfqf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 97
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data appears in the cycle after the request and then holds.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/j1939_link_frame_queue_filter.sv
// Top level of the J1939 data-link frame queue and destination filter.
//
//   channel   signals                               direction  beat carries
//   input     in_valid / in_ready                   in         one operation and its fields
//   output    out_valid / out_ready                 out        one result, last marks the run end
//   config    cfg_valid / cfg_ready, cfg_index      in         own or global address write
//
// Receive and send are taken in S_IDLE and give no result; a transmitter request passes
// through S_TX_RD and S_FLUSH, or only S_FLUSH when the outbound ring is empty.
// A tick passes S_TICK_RD for an outbound frame, S_DRAIN and S_FILT per inbound frame
// drained, and closes the run through S_DRAIN and S_FLUSH (S_DRAIN alone with no result).
// Reset is synchronous; it clears the ring pointers, the primed flag and the registers,
// but not the memories. A stalled output holds the result and the drain waits for it.
module j1939_link_frame_queue_filter (
  input  logic                           clk,
  input  logic                           rst,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [28:0]                    frame_id,
  input  logic [2:0]                     priority_req,
  input  logic [17:0]                    group_number,
  input  logic [7:0]                     target_addr,
  input  logic [7:0]                     sender_addr,
  input  logic [3:0]                     length,
  input  logic [63:0]                    payload,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     result_kind,
  output logic [28:0]                    out_id,
  output logic [15:0]                    out_group,
  output logic [7:0]                     out_dest,
  output logic [7:0]                     out_source,
  output logic [3:0]                     out_length,
  output logic [63:0]                    out_payload,
  output logic                           primed,
  output logic                           last,
  // Configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jlfqf_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int IAW = jlfqf_pkg::IN_AW;
  localparam int OAW = jlfqf_pkg::OUT_AW;
  localparam int CW  = jlfqf_pkg::CNT_W;
  localparam int FW  = $bits(jlfqf_pkg::frame_t);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TX_RD   = 3'd1;
  localparam logic [2:0] S_TICK_RD = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_FILT    = 3'd4;
  localparam logic [2:0] S_FLUSH   = 3'd5;

  logic [2:0]          state;
  logic [IAW-1:0]      in_head, in_tail;
  logic [OAW-1:0]      out_head, out_tail;
  logic                primed_flag;
  logic [7:0]          own_address, global_address;
  logic [CW-1:0]       cnt;
  jlfqf_pkg::result_t  res, pend, pend_last;
  logic                res_valid, pend_valid;

  logic                in_accept, in_full, in_empty, out_full, out_empty, out_free;
  logic                res_load;
  logic                in_we, in_re, out_we, out_re;
  logic [3:0]          len_c;
  logic [63:0]         data_c;
  jlfqf_pkg::frame_t   rx_frame, tx_frame, in_rd, out_rd;
  logic [FW-1:0]       in_rdata, out_rdata;
  logic                pdu1, filt_hit;
  jlfqf_pkg::result_t  filt_res, sent_res, txf_res, empty_res;

  // Ring pointer advance with wrap.
  function automatic logic [IAW-1:0] in_inc(input logic [IAW-1:0] p);
    return (p == IAW'(jlfqf_pkg::IN_DEPTH - 1)) ? '0 : p + IAW'(1);
  endfunction

  function automatic logic [OAW-1:0] out_inc(input logic [OAW-1:0] p);
    return (p == OAW'(jlfqf_pkg::OUT_DEPTH - 1)) ? '0 : p + OAW'(1);
  endfunction

  // Handshake and ring status.
  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign in_full   = (in_inc(in_tail) == in_head);
  assign in_empty  = (in_head == in_tail);
  assign out_full  = (out_inc(out_tail) == out_head);
  assign out_empty = (out_head == out_tail);
  assign out_free  = !res_valid || out_ready;

  // A held result moves into the output register on a filter hit or at the close of a run.
  assign res_load  = out_free &&
                     (((state == S_FILT) && filt_hit && pend_valid) || (state == S_FLUSH));

  // Frames to queue, with the byte count clamped and unused bytes cleared.
  assign len_c  = jlfqf_pkg::clamp_len(length);
  assign data_c = jlfqf_pkg::keep_bytes(payload, len_c);

  always_comb begin
    rx_frame      = '0;
    rx_frame.id   = frame_id;
    rx_frame.len  = len_c;
    rx_frame.data = data_c;
    tx_frame      = '0;
    tx_frame.id   = jlfqf_pkg::build_id(priority_req, group_number, target_addr, sender_addr);
    tx_frame.len  = len_c;
    tx_frame.data = data_c;
  end

  // Memory requests.
  assign in_we  = in_accept && (operation == jlfqf_pkg::OP_RECEIVE) && !in_full;
  assign out_we = in_accept && (operation == jlfqf_pkg::OP_SEND) && !out_full;
  assign out_re = in_accept && !out_empty &&
                  ((operation == jlfqf_pkg::OP_TICK) || (operation == jlfqf_pkg::OP_TXREQ));
  assign in_re  = (state == S_DRAIN) && (cnt < CW'(jlfqf_pkg::MAX_RESULTS)) && !in_empty;

  jlfqf_ram #(
    .DEPTH (jlfqf_pkg::IN_DEPTH),
    .WIDTH (FW)
  ) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_tail),
    .wdata (rx_frame),
    .re    (in_re),
    .raddr (in_head),
    .rdata (in_rdata)
  );

  jlfqf_ram #(
    .DEPTH (jlfqf_pkg::OUT_DEPTH),
    .WIDTH (FW)
  ) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_tail),
    .wdata (tx_frame),
    .re    (out_re),
    .raddr (out_head),
    .rdata (out_rdata)
  );

  assign in_rd  = jlfqf_pkg::frame_t'(in_rdata);
  assign out_rd = jlfqf_pkg::frame_t'(out_rdata);

  // Destination filter on the inbound frame just read.
  assign pdu1     = (in_rd.id[23:16] < jlfqf_pkg::PDU2_PF_MIN);
  assign filt_hit = !pdu1 || (in_rd.id[15:8] == global_address) ||
                    (in_rd.id[15:8] == own_address);

  // Result records for each kind.
  always_comb begin
    filt_res        = '0;
    filt_res.kind   = jlfqf_pkg::KIND_PDU;
    filt_res.group  = pdu1 ? {in_rd.id[23:16], 8'h00} : in_rd.id[23:8];
    filt_res.dest   = pdu1 ? in_rd.id[15:8] : global_address;
    filt_res.source = in_rd.id[7:0];
    filt_res.len    = in_rd.len;
    filt_res.data   = in_rd.data;
    filt_res.primed = primed_flag;

    sent_res        = '0;
    sent_res.kind   = jlfqf_pkg::KIND_SENT;
    sent_res.id     = out_rd.id;
    sent_res.len    = out_rd.len;
    sent_res.data   = out_rd.data;
    sent_res.primed = primed_flag;

    txf_res         = sent_res;
    txf_res.kind    = jlfqf_pkg::KIND_TX;

    empty_res       = '0;
    empty_res.kind  = jlfqf_pkg::KIND_EMPTY;

    pend_last       = pend;
    pend_last.last  = 1'b1;
  end

  // Sequencer, pointers, configuration and the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      in_head        <= '0;
      in_tail        <= '0;
      out_head       <= '0;
      out_tail       <= '0;
      primed_flag    <= 1'b0;
      own_address    <= 8'd0;
      global_address <= 8'd255;
      cnt            <= '0;
      res_valid      <= 1'b0;
      pend_valid     <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          jlfqf_pkg::REG_OWN:    own_address    <= cfg_data;
          jlfqf_pkg::REG_GLOBAL: global_address <= cfg_data;
          default: ;
        endcase
      end

      if (in_we)  in_tail  <= in_inc(in_tail);
      if (in_re)  in_head  <= in_inc(in_head);
      if (out_we) out_tail <= out_inc(out_tail);
      if (out_re) out_head <= out_inc(out_head);

      // Output register: a new result replaces the one leaving, or the register empties.
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            unique case (operation)
              jlfqf_pkg::OP_RECEIVE: ;
              jlfqf_pkg::OP_SEND: begin
                primed_flag <= 1'b1;
              end
              jlfqf_pkg::OP_TICK: begin
                cnt   <= '0;
                state <= out_empty ? S_DRAIN : S_TICK_RD;
              end
              jlfqf_pkg::OP_TXREQ: begin
                if (!out_empty) begin
                  primed_flag <= 1'b1;
                  state       <= S_TX_RD;
                end else begin
                  primed_flag <= 1'b0;
                  pend        <= empty_res;
                  pend_valid  <= 1'b1;
                  state       <= S_FLUSH;
                end
              end
              default: ;
            endcase
          end
        end
        // Outbound frame read for the transmitter.
        S_TX_RD: begin
          pend       <= txf_res;
          pend_valid <= 1'b1;
          state      <= S_FLUSH;
        end
        // Outbound frame read for a tick; the drain follows.
        S_TICK_RD: begin
          pend       <= sent_res;
          pend_valid <= 1'b1;
          cnt        <= CW'(1);
          state      <= S_DRAIN;
        end
        // Request the next inbound entry, or close the run.
        S_DRAIN: begin
          if (in_re) begin
            state <= S_FILT;
          end else if (pend_valid) begin
            state <= S_FLUSH;
          end else begin
            state <= S_IDLE;
          end
        end
        // Filter the entry; a hit pushes the held result out, not yet as the last one.
        S_FILT: begin
          if (!filt_hit) begin
            state <= S_DRAIN;
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              res <= pend;
            end
            pend       <= filt_res;
            pend_valid <= 1'b1;
            cnt        <= cnt + CW'(1);
            state      <= S_DRAIN;
          end
        end
        // Deliver the held result as the final beat of the run.
        S_FLUSH: begin
          if (out_free) begin
            res        <= pend_last;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output ports.
  assign out_valid   = res_valid;
  assign result_kind = res.kind;
  assign out_id      = res.id;
  assign out_group   = res.group;
  assign out_dest    = res.dest;
  assign out_source  = res.source;
  assign out_length  = res.len;
  assign out_payload = res.data;
  assign primed      = res.primed;
  assign last        = res.last;

endmodule
